// File: rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
// Both sample on the rising edge of clk and are switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check with a fixed failure message.
`define WTD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("wtd assertion failed");

// Check with a failure message given by the caller.
`define WTD_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

// File: rtl/core/wtd_pkg.sv
package wtd_pkg;

	localparam int ACC_BITS  = 32;
	localparam int TS_W      = 16;
	localparam int H_W       = 15;
	localparam int THR_W     = 31;
	localparam int MAG_W     = 16;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int STEP_W    = 4;
	localparam int DIV_W     = 16;
	localparam int DIV_CNT_W = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [TS_W-1:0]  PERIOD_RESET    = 16'd52304;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 31'd1673658368;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

	// Input opcodes.
	localparam logic OP_EDGE       = 1'b0;
	localparam logic OP_PERIOD_END = 1'b1;

	typedef enum logic [3:0] {
		U_IDLE,
		U_ELAPSED,
		U_WALK,
		U_DIV,
		U_ODD,
		U_REM,
		U_LANE,
		U_ISEDGE,
		U_SUM,
		U_MAG,
		U_SQUARE,
		U_JUDGE,
		U_EDGE,
		U_CLEAR
	} uop_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE    = 4'd0;
	localparam step_t ST_ELAPSED = 4'd1;
	localparam step_t ST_WALK    = 4'd2;
	localparam step_t ST_DIV     = 4'd3;
	localparam step_t ST_ODD     = 4'd4;
	localparam step_t ST_REM     = 4'd5;
	localparam step_t ST_LANE    = 4'd6;
	localparam step_t ST_ISEDGE  = 4'd7;
	localparam step_t ST_SUM     = 4'd8;
	localparam step_t ST_MAG     = 4'd9;
	localparam step_t ST_SQUARE  = 4'd10;
	localparam step_t ST_JUDGE   = 4'd11;
	localparam step_t ST_EDGE    = 4'd12;
	localparam step_t ST_CLEAR   = 4'd13;

	// One control word: the operation, the target taken when the operation's
	// condition holds, and the step that follows otherwise.
	typedef struct packed {
		uop_t  op;
		step_t jmp;
		step_t nxt;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			ST_IDLE:    w = '{op: U_IDLE,    jmp: ST_IDLE,   nxt: ST_ELAPSED};
			ST_ELAPSED: w = '{op: U_ELAPSED, jmp: ST_CLEAR,  nxt: ST_WALK};
			ST_WALK:    w = '{op: U_WALK,    jmp: ST_LANE,   nxt: ST_DIV};
			ST_DIV:     w = '{op: U_DIV,     jmp: ST_DIV,    nxt: ST_ODD};
			ST_ODD:     w = '{op: U_ODD,     jmp: ST_REM,    nxt: ST_REM};
			ST_REM:     w = '{op: U_REM,     jmp: ST_LANE,   nxt: ST_LANE};
			ST_LANE:    w = '{op: U_LANE,    jmp: ST_WALK,   nxt: ST_ISEDGE};
			ST_ISEDGE:  w = '{op: U_ISEDGE,  jmp: ST_EDGE,   nxt: ST_SUM};
			ST_SUM:     w = '{op: U_SUM,     jmp: ST_MAG,    nxt: ST_MAG};
			ST_MAG:     w = '{op: U_MAG,     jmp: ST_SQUARE, nxt: ST_SQUARE};
			ST_SQUARE:  w = '{op: U_SQUARE,  jmp: ST_JUDGE,  nxt: ST_JUDGE};
			ST_JUDGE:   w = '{op: U_JUDGE,   jmp: ST_JUDGE,  nxt: ST_IDLE};
			ST_EDGE:    w = '{op: U_EDGE,    jmp: ST_EDGE,   nxt: ST_IDLE};
			ST_CLEAR:   w = '{op: U_CLEAR,   jmp: ST_CLEAR,  nxt: ST_IDLE};
			default:    w = '{op: U_IDLE,    jmp: ST_IDLE,   nxt: ST_IDLE};
		endcase
		return w;
	endfunction

	typedef struct packed {
		logic start;
		logic run;
	} div_ctl_t;

	typedef struct packed {
		logic           last;
		logic           q_odd;
		logic [H_W-1:0] r;
	} div_stat_t;

endpackage

// File: rtl/core/wtd_div.sv
module wtd_div
	import wtd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DIV_W-1:0] dividend,
	input  logic [H_W-1:0]   divisor,
	output div_stat_t        stat
);

	// Restoring divider, one quotient bit per cycle. The quotient shifts into
	// the dividend register as the dividend bits shift out.
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     shifted;
	logic [DIV_W:0]       diff;

	assign shifted = {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= '0;
		end else if (ctl.run) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (ctl.run) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign stat.last  = (cnt_q == DIV_CNT_W'(DIV_W - 1));
	assign stat.q_odd = quo_q[0];
	assign stat.r     = rem_q[H_W-1:0];

endmodule

// File: rtl/core/walsh_tone_detector_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   24+1   tdata: timer_value[15:0], level[16], zero pad; tuser: opcode
// m_axis    out  8      tdata: detected[0], window_cleared[1], zero pad
// cfg       in   1+31   cfg_index selects period (0) or threshold (1), cfg_data value
//
// One item is in work at a time. The divider runs once per reference
// whenever a span crosses a reference flip.
// After reset the state equals a fresh window; no clearing pass is needed.
// s_tready is high only while the sequencer waits in its idle step; a result
// waits in the output register and stalls the final step until it is taken.
`include "assert_macros.svh"

module walsh_tone_detector_unit
	import wtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // timer_value[15:0], level[16], pad[23:17]
	input  logic                 s_tuser,   // opcode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // detected[0], window_cleared[1], pad[7:2]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [TS_W-1:0]  period_q;
	logic [THR_W-1:0] thr_q;

	// Sequencer.
	step_t  step_q;
	ucode_t uw;
	logic   cond;
	logic   in_acc;
	logic   out_free;
	logic   res_load;

	// Latched item.
	logic            opcode_q;
	logic            level_q;
	logic [TS_W-1:0] ts_q;

	// Detector state. Index 0 is the in-phase reference, index 1 the quadrature.
	logic [ACC_BITS-1:0] acc_q [2];
	logic [ACC_BITS-1:0] sum_q [2];
	logic                phase_q [2];
	logic [TS_W-1:0]     rem_q [2];
	logic [TS_W-1:0]     prev_timer_q;
	logic                edge_seen_q;

	// Working registers.
	logic [TS_W-1:0]  t_q;
	logic [H_W-1:0]   h_q;
	logic             lane_q;
	logic [MAG_W-1:0] mag_q [2];
	logic             big_q;
	logic [SQ_W-1:0]  sq_q [2];

	// Output register.
	logic m_tvalid_q;
	logic detected_q;
	logic cleared_q;

	// Shared divider.
	div_ctl_t  div_ctl;
	div_stat_t div_stat;

	// Datapath signals.
	logic                span_lvl;
	logic [TS_W-1:0]     walk_rem;
	logic [TS_W-1:0]     elapsed;
	logic [H_W-1:0]      half;
	logic                credit_en;
	logic [TS_W-1:0]     credit_amt;
	logic [ACC_BITS-1:0] credit_ext;
	logic [ACC_BITS-1:0] acc_credit;
	logic [ACC_BITS-1:0] mag_full [2];
	logic [SQ_W:0]       energy;
	logic                hit;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (step_q == ST_IDLE);
	assign uw       = ucode_rom(step_q);

	// A finishing step loads a new result into the output register this cycle.
	assign res_load = out_free &&
		(uw.op == U_JUDGE || uw.op == U_EDGE || uw.op == U_CLEAR);

	// The span before an edge had the level opposite to the new one; at a period
	// end the level given is the level of the span itself.
	assign span_lvl = (opcode_q == OP_PERIOD_END) ? level_q : !level_q;
	assign walk_rem = rem_q[lane_q];

	// Ticks since the previous item, wrapping at the carrier period.
	always_comb begin
		if (ts_q < prev_timer_q) begin
			elapsed = ts_q + period_q - prev_timer_q;
		end else begin
			elapsed = ts_q - prev_timer_q;
		end
		half = period_q[TS_W-1:1];
		if (half == '0) begin
			half = H_W'(1);
		end
	end

	// Condition of the current control word; when it holds, the jump is taken.
	always_comb begin
		unique case (uw.op)
			U_IDLE:    cond = !in_acc;
			U_ELAPSED: cond = (opcode_q == OP_PERIOD_END) && !edge_seen_q;
			U_WALK:    cond = (t_q == '0) || (t_q < walk_rem);
			U_DIV:     cond = !div_stat.last;
			U_LANE:    cond = !lane_q;
			U_ISEDGE:  cond = (opcode_q == OP_EDGE);
			U_JUDGE,
			U_EDGE,
			U_CLEAR:   cond = !out_free;
			default:   cond = 1'b0;
		endcase
	end

	assign div_ctl.start = (uw.op == U_WALK) && !cond;
	assign div_ctl.run   = (uw.op == U_DIV);

	wtd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (t_q - walk_rem),
		.divisor  (h_q),
		.stat     (div_stat)
	);

	// One credit per step into the accumulator of the active lane: ticks are
	// added while the span level matches the reference phase, subtracted else.
	always_comb begin
		credit_en  = 1'b0;
		credit_amt = '0;
		unique case (uw.op)
			U_WALK: begin
				credit_en  = (t_q != '0);
				credit_amt = (t_q < walk_rem) ? t_q : walk_rem;
			end
			U_ODD: begin
				credit_en  = div_stat.q_odd;
				credit_amt = {1'b0, h_q};
			end
			U_REM: begin
				credit_en  = (div_stat.r != '0);
				credit_amt = {1'b0, div_stat.r};
			end
			default: begin
				credit_en  = 1'b0;
			end
		endcase
		credit_ext = {{(ACC_BITS - TS_W){1'b0}}, credit_amt};
		if (span_lvl ^ phase_q[lane_q]) begin
			acc_credit = acc_q[lane_q] - credit_ext;
		end else begin
			acc_credit = acc_q[lane_q] + credit_ext;
		end
	end

	// Magnitudes of the signed sums. A magnitude of 2^16 or more always exceeds
	// the threshold, so only the low half goes on to the squarers.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag_full[i] = sum_q[i][ACC_BITS-1] ? (~sum_q[i] + 1'b1) : sum_q[i];
		end
		energy = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
		hit    = big_q || (energy >= {{(SQ_W + 1 - THR_W){1'b0}}, thr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RESET;
			thr_q        <= THRESHOLD_RESET;
			step_q       <= ST_IDLE;
			opcode_q     <= OP_EDGE;
			level_q      <= 1'b0;
			ts_q         <= '0;
			acc_q[0]     <= '0;
			acc_q[1]     <= '0;
			sum_q[0]     <= '0;
			sum_q[1]     <= '0;
			phase_q[0]   <= 1'b0;
			phase_q[1]   <= 1'b0;
			rem_q[0]     <= PERIOD_RESET >> 1;
			rem_q[1]     <= PERIOD_RESET >> 2;
			prev_timer_q <= '0;
			edge_seen_q  <= 1'b0;
			t_q          <= '0;
			h_q          <= '0;
			lane_q       <= 1'b0;
			big_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
			detected_q   <= 1'b0;
			cleared_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PERIOD:    period_q <= cfg_data[TS_W-1:0];
					CFG_THRESHOLD: thr_q    <= cfg_data;
					default:       thr_q    <= thr_q;
				endcase
			end

			if (m_tvalid_q && m_tready && !res_load) begin
				m_tvalid_q <= 1'b0;
			end

			step_q <= cond ? uw.jmp : uw.nxt;

			if (credit_en) begin
				acc_q[lane_q] <= acc_credit;
			end

			unique case (uw.op)
				U_IDLE: begin
					if (in_acc) begin
						ts_q     <= s_tdata[TS_W-1:0];
						level_q  <= s_tdata[TS_W];
						opcode_q <= s_tuser;
					end
				end
				U_ELAPSED: begin
					if (!cond) begin
						t_q          <= elapsed;
						h_q          <= half;
						prev_timer_q <= ts_q;
						lane_q       <= 1'b0;
					end
				end
				U_WALK: begin
					if (!cond) begin
						phase_q[lane_q] <= !phase_q[lane_q];
					end else if (t_q != '0) begin
						rem_q[lane_q] <= walk_rem - t_q;
					end
				end
				U_ODD: begin
					if (div_stat.q_odd) begin
						phase_q[lane_q] <= !phase_q[lane_q];
					end
				end
				U_REM: begin
					rem_q[lane_q] <= {1'b0, h_q} - {1'b0, div_stat.r};
				end
				U_LANE: begin
					lane_q <= 1'b1;
				end
				U_SUM: begin
					sum_q[0]    <= sum_q[0] + acc_q[0];
					sum_q[1]    <= sum_q[1] + acc_q[1];
					edge_seen_q <= 1'b0;
				end
				U_MAG: begin
					big_q <= (|mag_full[0][ACC_BITS-1:MAG_W]) ||
						(|mag_full[1][ACC_BITS-1:MAG_W]);
				end
				U_JUDGE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						detected_q <= hit;
						cleared_q  <= 1'b0;
						if (!hit) begin
							sum_q[0] <= acc_q[0];
							sum_q[1] <= acc_q[1];
						end
					end
				end
				U_EDGE: begin
					if (out_free) begin
						m_tvalid_q  <= 1'b1;
						detected_q  <= 1'b0;
						cleared_q   <= 1'b0;
						edge_seen_q <= 1'b1;
					end
				end
				U_CLEAR: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						detected_q   <= 1'b0;
						cleared_q    <= 1'b1;
						acc_q[0]     <= '0;
						acc_q[1]     <= '0;
						sum_q[0]     <= '0;
						sum_q[1]     <= '0;
						phase_q[0]   <= 1'b0;
						phase_q[1]   <= 1'b0;
						rem_q[0]     <= period_q >> 1;
						rem_q[1]     <= period_q >> 2;
						prev_timer_q <= '0;
					end
				end
				default: begin
					lane_q <= lane_q;
				end
			endcase
		end
	end

	// The squarers hold no control state, so they carry no reset.
	always_ff @(posedge clk) begin
		if (uw.op == U_MAG) begin
			mag_q[0] <= mag_full[0][MAG_W-1:0];
			mag_q[1] <= mag_full[1][MAG_W-1:0];
		end
		if (uw.op == U_SQUARE) begin
			sq_q[0] <= mag_q[0] * mag_q[0];
			sq_q[1] <= mag_q[1] * mag_q[1];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, cleared_q, detected_q};

	// An accepted beat always starts the program at its first working step.
	`WTD_ASSERT(a_accept_starts, in_acc |=> (step_q == ST_ELAPSED))

	// A result appears only from one of the three finishing steps.
	`WTD_ASSERT_MSG(a_result_source, $rose(m_tvalid_q) |->
		($past(step_q) == ST_JUDGE || $past(step_q) == ST_EDGE ||
		$past(step_q) == ST_CLEAR), "result raised outside a finishing step")

	// A cleared window never reports a detection at the same time.
	`WTD_ASSERT_MSG(a_flags_exclusive, m_tvalid_q |-> !(detected_q && cleared_q),
		"detected and window_cleared both set")

	// The divider hands over exactly when its last iteration completes.
	`WTD_ASSERT(a_div_handover, (step_q == ST_ODD) |-> $past(div_stat.last))

endmodule
